FILE: hw/rtl/mcmp_pkg.sv
`default_nettype none

package mcmp_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned DATA_W      = 7;
    localparam int unsigned LEN_W       = 2;
    localparam int unsigned OUT_W       = BYTE_W + 2 * DATA_W + LEN_W;
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QUEUE_PTR_W = 1;
    localparam int unsigned QUEUE_CNT_W = 2;

    localparam logic [BYTE_W-1:0] RT_FIRST    = 8'hF8;
    localparam logic [BYTE_W-1:0] SYS_FIRST   = 8'hF0;
    localparam logic [3:0]        PROG_CHANGE = 4'hC;
    localparam logic [3:0]        CHAN_PRESS  = 4'hD;

    localparam logic [LEN_W-1:0] LEN_NONE = 2'd0;
    localparam logic [LEN_W-1:0] LEN_ONE  = 2'd1;
    localparam logic [LEN_W-1:0] LEN_TWO  = 2'd2;
    localparam logic [LEN_W-1:0] LEN_THREE = 2'd3;

    typedef enum logic [1:0] {
        KIND_REALTIME,
        KIND_SYSTEM,
        KIND_CHANNEL,
        KIND_DATA
    } byte_kind_t;

    typedef struct packed {
        byte_kind_t        kind;
        logic [BYTE_W-1:0] value;
    } parse_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] status;
        logic [DATA_W-1:0] data1;
        logic [DATA_W-1:0] data2;
        logic [LEN_W-1:0]  length;
    } midi_msg_t;

    // program change and channel pressure carry one data byte
    function automatic logic [LEN_W-1:0] length_of(input logic [BYTE_W-1:0] st);
        logic [LEN_W-1:0] len;
        len = LEN_THREE;
        if (st[7:4] == PROG_CHANGE || st[7:4] == CHAN_PRESS)
        begin
            len = LEN_TWO;
        end
        return len;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/mcmp_front.sv
`default_nettype none

module mcmp_front
    import mcmp_pkg::*;
(
    input  wire logic [BYTE_W-1:0] rx_byte,
    output parse_item_t            item
);

    byte_kind_t kind;

    always_comb
    begin
        unique case ({rx_byte[7], rx_byte >= RT_FIRST, rx_byte >= SYS_FIRST})
            3'b111:  kind = KIND_REALTIME;
            3'b101:  kind = KIND_SYSTEM;
            3'b100:  kind = KIND_CHANNEL;
            default: kind = KIND_DATA;
        endcase
    end

    assign item.kind  = kind;
    assign item.value = rx_byte;

endmodule

`default_nettype wire

FILE: hw/rtl/mcmp_queue.sv
`default_nettype none

module mcmp_queue
    import mcmp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    input  wire parse_item_t push_item,
    output logic             not_full,
    input  wire logic        pop,
    output logic             not_empty,
    output parse_item_t      head_item
);

    parse_item_t             entries_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0]  count_reg, count_next;
    logic                    do_push, do_pop;

    assign not_full  = (count_reg != QUEUE_CNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_item = entries_reg[rd_ptr_reg];
    assign do_push   = push && not_full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/mcmp_back.sv
`default_nettype none

module mcmp_back
    import mcmp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        item_valid,
    input  wire parse_item_t item,
    output logic             item_pop,
    output logic             msg_valid,
    input  wire logic        msg_ready,
    output midi_msg_t        msg
);

    logic [BYTE_W-1:0] running_status_reg, running_status_next;
    logic [LEN_W-1:0]  bytes_expected_reg, bytes_expected_next;
    logic [LEN_W-1:0]  bytes_collected_reg, bytes_collected_next;
    logic [DATA_W-1:0] first_data_reg, first_data_next;
    logic              out_valid_reg, out_valid_next;
    midi_msg_t         out_msg_reg, out_msg_next;
    logic              emit;
    midi_msg_t         result;
    logic [LEN_W-1:0]  exp_eff;
    logic [DATA_W-1:0] data_in;

    // output register drains in the same cycle it refills
    assign item_pop = item_valid && (!out_valid_reg || msg_ready);
    assign data_in  = item.value[DATA_W-1:0];

    always_comb
    begin
        running_status_next  = running_status_reg;
        bytes_expected_next  = bytes_expected_reg;
        bytes_collected_next = bytes_collected_reg;
        first_data_next      = first_data_reg;
        emit                 = 1'b0;
        result               = '0;
        exp_eff              = bytes_expected_reg;

        unique case (item.kind)
            KIND_REALTIME:
            begin
                emit          = 1'b1;
                result.status = item.value;
                result.length = LEN_ONE;
            end
            KIND_SYSTEM:
            begin
                bytes_expected_next  = LEN_NONE;
                bytes_collected_next = '0;
            end
            KIND_CHANNEL:
            begin
                running_status_next  = item.value;
                bytes_expected_next  = length_of(item.value);
                bytes_collected_next = '0;
            end
            default:
            begin
                // idle with running status: data byte opens a new message
                if (bytes_expected_reg == LEN_NONE)
                begin
                    exp_eff = (running_status_reg == '0) ? LEN_NONE
                                                         : length_of(running_status_reg);
                end
                if (exp_eff == LEN_TWO)
                begin
                    emit                 = 1'b1;
                    result.status        = running_status_reg;
                    result.data1         = data_in;
                    result.length        = LEN_TWO;
                    bytes_expected_next  = LEN_NONE;
                    bytes_collected_next = '0;
                end
                else if (exp_eff == LEN_THREE)
                begin
                    if (bytes_expected_reg == LEN_NONE || bytes_collected_reg == '0)
                    begin
                        first_data_next      = data_in;
                        bytes_expected_next  = LEN_THREE;
                        bytes_collected_next = 2'd1;
                    end
                    else
                    begin
                        emit                 = 1'b1;
                        result.status        = running_status_reg;
                        result.data1         = first_data_reg;
                        result.data2         = data_in;
                        result.length        = LEN_THREE;
                        bytes_expected_next  = LEN_NONE;
                        bytes_collected_next = '0;
                    end
                end
            end
        endcase

        out_msg_next   = out_msg_reg;
        out_valid_next = out_valid_reg;
        if (item_pop && emit)
        begin
            out_msg_next   = result;
            out_valid_next = 1'b1;
        end
        else if (msg_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_status_reg  <= '0;
            bytes_expected_reg  <= LEN_NONE;
            bytes_collected_reg <= '0;
            first_data_reg      <= '0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            if (item_pop)
            begin
                running_status_reg  <= running_status_next;
                bytes_expected_reg  <= bytes_expected_next;
                bytes_collected_reg <= bytes_collected_next;
                first_data_reg      <= first_data_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_msg_reg <= out_msg_next;
    end

    assign msg_valid = out_valid_reg;
    assign msg       = out_msg_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/midi_channel_message_parser.sv
// MIDI byte stream parser with running status. Takes one received byte per
// word on the slave side and delivers complete messages on the master side:
// real-time bytes pass through at once as one-byte messages, channel messages
// come out when their last data byte arrives, and data bytes under running
// status start new messages. Sustained rate is one byte per clock while the
// master side accepts; a byte's message passes through the two-entry byte
// queue and then the output register (the byte is read from the queue while
// the output register is empty or draining, and its message lands there at
// the end of that cycle). The queue absorbs two words while the output stalls.
`default_nettype none

module midi_channel_message_parser
    import mcmp_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [BYTE_W-1:0] s_tdata,  // [7:0] rx_byte
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [OUT_W-1:0]       m_tdata   // [7:0] msg_status, [14:8] msg_data1,
                                             // [21:15] msg_data2, [23:22] msg_length
);

    parse_item_t front_item;
    parse_item_t head_item;
    logic        q_not_full;
    logic        q_not_empty;
    logic        q_pop;
    midi_msg_t   msg;

    mcmp_front u_front (
        .rx_byte (s_tdata),
        .item    (front_item)
    );

    mcmp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s_tvalid),
        .push_item (front_item),
        .not_full  (q_not_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_item (head_item)
    );

    mcmp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (q_not_empty),
        .item       (head_item),
        .item_pop   (q_pop),
        .msg_valid  (m_tvalid),
        .msg_ready  (m_tready),
        .msg        (msg)
    );

    assign s_tready = q_not_full;
    assign m_tdata  = {msg.length, msg.data2, msg.data1, msg.status};

endmodule

`default_nettype wire

FILE: hw/rtl/mcmp_checker.sv
`default_nettype none

module mcmp_checker
    import mcmp_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              m_tvalid,
    input wire logic              m_tready,
    input wire logic [OUT_W-1:0]  m_tdata
);

    logic [BYTE_W-1:0] st;
    logic [LEN_W-1:0]  len;

    assign st  = m_tdata[7:0];
    assign len = m_tdata[23:22];

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result word dropped while stalled");

    a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> len != LEN_NONE)
        else $error("message with zero length");

    a_realtime_shape: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && len == LEN_ONE |-> st >= RT_FIRST && m_tdata[21:8] == '0)
        else $error("one-byte message is not a clean real-time byte");

    a_channel_shape: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && len != LEN_ONE |-> st[7] && st < SYS_FIRST &&
            len == length_of(st))
        else $error("channel message status and length disagree");

endmodule

bind midi_channel_message_parser mcmp_checker u_mcmp_checker (.*);

`default_nettype wire

FILE: verif/midi_channel_message_parser_tb.sv
`default_nettype none

module midi_channel_message_parser_tb;
    import mcmp_pkg::*;

    localparam int unsigned IDLE_LIMIT  = 2000;
    localparam int unsigned DRAIN_TICKS = 20;
    localparam int unsigned HOLD_TICKS  = 120;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [BYTE_W-1:0]   s_tdata = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [OUT_W-1:0]    m_tdata;

    midi_channel_message_parser u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // [7:0] rx_byte
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)    // [7:0] status, [14:8] data1, [21:15] data2, [23:22] length
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // parser state as seen by the byte stream
    logic [BYTE_W-1:0] run_status = '0;
    logic [LEN_W-1:0]  pend_len   = LEN_NONE;
    logic [1:0]        data_cnt   = '0;
    logic [DATA_W-1:0] held_data1 = '0;

    midi_msg_t   expected_msgs[$];
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned stall_request = 0;
    int unsigned stall_left    = 0;
    int unsigned errors        = 0;
    int unsigned bytes_sent    = 0;
    int unsigned msgs_checked  = 0;
    int unsigned msgs_by_len[4] = '{0, 0, 0, 0};
    int unsigned quiet_cycles  = 0;

    function automatic logic [LEN_W-1:0] msg_len_for(input logic [BYTE_W-1:0] st);
        logic [LEN_W-1:0] len;
        len = LEN_THREE;
        if (st[7:4] == PROG_CHANGE || st[7:4] == CHAN_PRESS)
        begin
            len = LEN_TWO;
        end
        return len;
    endfunction

    function automatic byte_kind_t classify(input logic [BYTE_W-1:0] b);
        byte_kind_t k;
        if (b >= RT_FIRST)
            k = KIND_REALTIME;
        else if (b >= SYS_FIRST)
            k = KIND_SYSTEM;
        else if (b[7])
            k = KIND_CHANNEL;
        else
            k = KIND_DATA;
        return k;
    endfunction

    function automatic void predict_msg(input logic [BYTE_W-1:0] b);
        midi_msg_t m;
        m = '0;
        case (classify(b))
            KIND_REALTIME:
            begin
                m.status = b;
                m.length = LEN_ONE;
                expected_msgs.push_back(m);
            end
            KIND_SYSTEM:
            begin
                // partial message dropped, running status survives
                pend_len = LEN_NONE;
                data_cnt = '0;
            end
            KIND_CHANNEL:
            begin
                run_status = b;
                pend_len   = msg_len_for(b);
                data_cnt   = '0;
            end
            default:
            begin
                if (pend_len == LEN_NONE && run_status != '0)
                begin
                    pend_len = msg_len_for(run_status);
                    data_cnt = '0;
                end
                if (pend_len == LEN_TWO)
                begin
                    m.status = run_status;
                    m.data1  = b[DATA_W-1:0];
                    m.length = LEN_TWO;
                    expected_msgs.push_back(m);
                    pend_len = LEN_NONE;
                    data_cnt = '0;
                end
                else if (pend_len == LEN_THREE)
                begin
                    if (data_cnt == '0)
                    begin
                        held_data1 = b[DATA_W-1:0];
                        data_cnt   = 2'd1;
                    end
                    else
                    begin
                        m.status = run_status;
                        m.data1  = held_data1;
                        m.data2  = b[DATA_W-1:0];
                        m.length = LEN_THREE;
                        expected_msgs.push_back(m);
                        pend_len = LEN_NONE;
                        data_cnt = '0;
                    end
                end
            end
        endcase
    endfunction

    function automatic void check_field(input string name, input int unsigned exp_v,
                                        input int unsigned act_v);
        if (exp_v != act_v)
        begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            errors++;
        end
    endfunction

    // called and returns at a falling edge
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do
            @(posedge clk);
        while (!s_tready);
        predict_msg(b);
        bytes_sent++;
        @(negedge clk);
    endtask

    // receiver: random stalls, or a long hold-off when asked for
    always @(negedge clk)
    begin
        if (stall_request != 0)
        begin
            stall_left    = stall_request;
            stall_request = 0;
        end
        if (stall_left != 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        midi_msg_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_msgs.size() == 0)
            begin
                $error("unexpected message word: 0x%0h", m_tdata);
                errors++;
            end
            else
            begin
                want = expected_msgs.pop_front();
                check_field("msg_status", 32'(want.status), 32'(m_tdata[7:0]));
                check_field("msg_data1",  32'(want.data1),  32'(m_tdata[14:8]));
                check_field("msg_data2",  32'(want.data2),  32'(m_tdata[21:15]));
                check_field("msg_length", 32'(want.length), 32'(m_tdata[23:22]));
                msgs_checked++;
                msgs_by_len[m_tdata[23:22]]++;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic test_directed();
        logic [BYTE_W-1:0] seq[$];
        seq = {
            8'h00, 8'h7F,               // data with no running status: dropped
            8'hF8, 8'hFF,               // real-time extremes
            8'h90, 8'h00, 8'h7F,        // note on
            8'h55, 8'h2A,               // running status, three-byte
            8'hC3, 8'h7F, 8'h00,        // program change, then running status
            8'hDF, 8'h40,               // channel pressure
            8'hB0, 8'h07, 8'hFE, 8'h64, // real-time in the middle of a message
            8'hE5, 8'h11, 8'hF7,        // system byte drops partial message
            8'h22, 8'h33,               // running status still E5
            8'h80, 8'h01, 8'h02,
            8'hEF, 8'h7F, 8'h7F
        };
        foreach (seq[i])
            send_byte(seq[i]);
    endtask

    task automatic test_random_traffic(input int unsigned n_items);
        int unsigned       start;
        int unsigned       r;
        int unsigned       n_data;
        logic [BYTE_W-1:0] cur_status;
        start      = bytes_sent;
        cur_status = '0;
        while (bytes_sent - start < n_items)
        begin
            r = $urandom_range(99);
            if (r < 10)
                send_byte(BYTE_W'($urandom_range(255)));
            else if (r < 17)
                send_byte(BYTE_W'($urandom_range(8'hFF, RT_FIRST)));
            else if (r < 22)
                send_byte(BYTE_W'($urandom_range(RT_FIRST - 1, SYS_FIRST)));
            else
            begin
                if (r >= 55 || cur_status == '0)
                begin
                    cur_status = BYTE_W'($urandom_range(SYS_FIRST - 1, 8'h80));
                    send_byte(cur_status);
                end
                n_data = 32'(msg_len_for(cur_status)) - 1;
                // occasionally cut the message short
                if ($urandom_range(9) == 0)
                    n_data--;
                repeat (n_data)
                begin
                    if ($urandom_range(9) == 0)
                        send_byte(BYTE_W'($urandom_range(8'hFF, RT_FIRST)));
                    send_byte(BYTE_W'($urandom_range(127)));
                end
            end
        end
    endtask

    task automatic test_backpressure();
        stall_request = HOLD_TICKS;
        repeat (14)
        begin
            send_byte(BYTE_W'($urandom_range(8'h9F, 8'h90)));
            send_byte(BYTE_W'($urandom_range(127)));
            send_byte(BYTE_W'($urandom_range(127)));
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_idle_pct = 21;
        recv_idle_pct = 84;
        test_directed();
        test_random_traffic(135);

        send_idle_pct = 84;
        recv_idle_pct = 21;
        test_random_traffic(135);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(135);
        test_backpressure();

        s_tvalid <= 1'b0;
        while (expected_msgs.size() != 0)
            @(posedge clk);
        repeat (DRAIN_TICKS) @(posedge clk);

        $display("%0d bytes sent (directed, random, long output stall); %0d messages checked",
                 bytes_sent, msgs_checked);
        $display("by length: %0d real-time, %0d two-byte, %0d three-byte",
                 msgs_by_len[1], msgs_by_len[2], msgs_by_len[3]);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire

FILE: sim.f
hw/rtl/mcmp_pkg.sv
hw/rtl/mcmp_front.sv
hw/rtl/mcmp_queue.sv
hw/rtl/mcmp_back.sv
hw/rtl/midi_channel_message_parser.sv
hw/rtl/mcmp_checker.sv
verif/midi_channel_message_parser_tb.sv
